// ===== sv/u8u16_pkg.sv =====
package u8u16_pkg;

  // Continuation bytes still expected for the open sequence
  localparam logic [1:0] PEND_IDLE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;

  // Lead byte of a two-byte sequence: 110xxxxx
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_CODE = 8'hC0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        too_wide;
    logic        out_last;
  } out_item_t;

  typedef struct packed {
    logic narrow_mode;
  } cfg_item_t;

  // Decoder state carried from one byte to the next
  typedef struct packed {
    logic [15:0] partial_unit;
    logic [1:0]  bytes_pending;
  } dec_state_t;

endpackage

// ===== sv/u8u16_if.sv =====
interface u8u16_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/utf8_to_utf16_bmp_decoder.sv =====
// UTF-8 to UTF-16 (BMP) stream decoder.
//
// in_stream carries one UTF-8 byte per item plus a flag on the last byte of
// a string. out_stream carries one 16-bit code unit per completed character,
// a too_wide flag (narrow mode and unit above 0xFF) and out_last when the
// unit was completed by the string's last byte. Input is not validated.
// cfg writes the narrow_mode register; it is always ready and should only
// be written while the block is idle.
//
// Throughput: one byte per cycle unless a completed unit waits on a stalled
// receiver. A byte accepted into the input register loads its unit, if any,
// into the result register, from which the receiver takes it.
// Lead bytes and inner continuation bytes produce no item and never wait on
// the output. When the receiver stalls, the result register holds its item;
// bytes that complete no unit keep flowing, and the first byte that completes
// a unit waits in the input register, which drops in_stream.ready.
// Reset (synchronous) empties both registers, closes any open sequence and
// clears narrow_mode.
module utf8_to_utf16_bmp_decoder
  import u8u16_pkg::*;
(
  input  logic clk,
  input  logic rst,
  u8u16_if.sink   in_stream,
  u8u16_if.source out_stream,
  u8u16_if.sink   cfg
);

  logic       s1_valid;
  in_item_t   s1_item;
  logic       out_valid;
  out_item_t  out_item;
  dec_state_t st;
  dec_state_t st_next;
  logic       narrow;
  logic       emit;
  out_item_t  res;
  logic       proceed;

  u8u16_dec u_dec (
    .item   (s1_item),
    .cur    (st),
    .narrow (narrow),
    .nxt    (st_next),
    .emit   (emit),
    .res    (res)
  );

  // a byte moves on when its result has room, or when it makes no result
  assign proceed         = s1_valid && (!out_valid || out_stream.ready || !emit);
  assign in_stream.ready = !s1_valid || proceed;
  assign cfg.ready       = 1'b1;

  assign out_stream.valid = out_valid;
  assign out_stream.data  = out_item;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      narrow <= 1'b0;
    end else if (cfg.valid) begin
      narrow <= cfg.data.narrow_mode;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_stream.ready) begin
      s1_valid <= in_stream.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      s1_item <= in_stream.data;
    end
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (proceed) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proceed && emit) begin
      out_valid <= 1'b1;
    end else if (out_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && emit) begin
      out_item <= res;
    end
  end

endmodule

// ===== sv/u8u16_dec.sv =====
module u8u16_dec
  import u8u16_pkg::*;
(
  input  in_item_t   item,
  input  dec_state_t cur,
  input  logic       narrow,
  output dec_state_t nxt,
  output logic       emit,
  output out_item_t  res
);

  logic [7:0]  b;
  logic [15:0] unit;

  assign b = item.in_byte;

  // One decode step: extend the open sequence or start a new one
  always_comb begin
    nxt  = cur;
    emit = 1'b0;
    unit = '0;
    unique case (cur.bytes_pending)
      PEND_ONE: begin
        unit = cur.partial_unit | {10'd0, b[5:0]};
        emit = 1'b1;
        nxt  = '0;
      end
      PEND_TWO: begin
        nxt.partial_unit  = cur.partial_unit | {4'd0, b[5:0], 6'd0};
        nxt.bytes_pending = PEND_ONE;
      end
      default: begin
        if (!b[7]) begin
          unit = {8'd0, b};
          emit = 1'b1;
          nxt  = '0;
        end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
          nxt.partial_unit  = {5'd0, b[4:0], 6'd0};
          nxt.bytes_pending = PEND_ONE;
        end else begin
          // three-byte lead, also stray continuation and 4-byte leads
          nxt.partial_unit  = {b[3:0], 12'd0};
          nxt.bytes_pending = PEND_TWO;
        end
      end
    endcase
    // truncated sequence at end of string is dropped
    if (item.in_last && !emit) begin
      nxt = '0;
    end
  end

  assign res.code_unit = unit;
  assign res.too_wide  = narrow && (unit[15:8] != 8'd0);
  assign res.out_last  = item.in_last;

endmodule

// ===== sv/u8u16_chk.sv =====
module u8u16_chk
  import u8u16_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output item changed or dropped");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // input side is open whenever the result register is empty
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // too_wide only on units above 0xFF
  a_too_wide: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.too_wide |-> out_data.code_unit[15:8] != 8'd0)
    else $error("too_wide on a narrow unit");

  // a new result needs an earlier accepted input byte
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output item without input byte");

endmodule

bind utf8_to_utf16_bmp_decoder u8u16_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_stream.valid),
  .in_ready  (in_stream.ready),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_data  (out_stream.data)
);
